@@ src/dba_pkg.sv @@
`timescale 1ns / 1ps

package dba_pkg;

	// Default map sizes and word width
	localparam int DATA_BITS_DEF  = 4096;
	localparam int INODE_BITS_DEF = 1024;
	localparam int WORD_BITS_DEF  = 32;

	// Fixed field widths
	localparam int IDX_W      = 12;
	localparam int DATA_CW    = 13;
	localparam int INODE_CW   = 11;
	localparam int FREE_W     = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd1;

	typedef enum logic [1:0] {
		FN_TEST  = 2'd0,
		FN_SET   = 2'd1,
		FN_CLEAR = 2'd2,
		FN_FIND  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STS_OK    = 3'd0,
		STS_RANGE = 3'd1,
		STS_USED  = 3'd2,
		STS_FREE  = 3'd3,
		STS_NONE  = 3'd4
	} status_t;

	typedef struct packed {
		func_t             func;
		logic              map_sel;
		logic [IDX_W-1:0]  bit_index;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic              used;
		logic [IDX_W-1:0]  found_index;
		logic [FREE_W-1:0] free_left;
	} rsp_t;

endpackage

@@ src/dba_bitmap.sv @@
`timescale 1ns / 1ps

// One bitmap store: synchronous RAM with a valid bit per word.
// A word that has not been written since reset or clear reads as all free.
module dba_bitmap #(
	parameter int WORDS     = 128,
	parameter int WORD_BITS = 32,
	localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data
);

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORDS-1:0]     valid_q;
	logic                 rvalid_q;

	// Storage array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Per-word valid bits, cleared at once by reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

@@ src/dual_bitmap_allocator.sv @@
`timescale 1ns / 1ps

// Two first-fit allocation bitmaps: one for data blocks, one for inodes.
// Request channel: req is taken when start is high and busy is low. Each
// request tests, sets, clears one bit or finds the lowest free bit of the
// selected map. Exactly one result per request appears on rsp for a single
// cycle with done high; the receiver cannot stall, so it must sample then.
// Test, set and clear read the word in S_READ, then modify it and write it
// back in S_EVAL; the next request may be issued in the done cycle.
// Find streams the map words out of the RAM one per cycle and stops at the
// first word with a free bit, at the map's last word, or when the map is full.
// Config channel: cfg_ready is always high; index 0 writes data_count,
// index 1 inode_count (low 11 bits), others are dropped. A write saturates
// to the map's capacity, empties that map and sets its free counter to the
// new size. Write config only while the block is idle.
// Reset: both maps empty, sizes and free counters at full capacity; the
// per-word valid bits make this immediate, there is no clearing pass.
module dual_bitmap_allocator #(
	parameter int DATA_BITS  = dba_pkg::DATA_BITS_DEF,
	parameter int INODE_BITS = dba_pkg::INODE_BITS_DEF,
	parameter int WORD_BITS  = dba_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  dba_pkg::req_t                      req,
	output logic                               done,
	output dba_pkg::rsp_t                      rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int WSH    = $clog2(WORD_BITS);
	localparam int DWORDS = (DATA_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int IWORDS = (INODE_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int DAW    = (DWORDS > 1) ? $clog2(DWORDS) : 1;
	localparam int IAW    = (IWORDS > 1) ? $clog2(IWORDS) : 1;
	localparam int PW     = (DAW > IAW) ? DAW : IAW;
	localparam int FULL_W = PW + WSH;
	localparam int FW     = dba_pkg::FREE_W;
	localparam int DCW    = dba_pkg::DATA_CW;
	localparam int ICW    = dba_pkg::INODE_CW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EVAL = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t            state_q;
	dba_pkg::req_t     req_q;
	logic [PW-1:0]     wptr_q;
	logic [DCW-1:0]    data_count_q;
	logic [ICW-1:0]    inode_count_q;
	logic [DCW-1:0]    data_free_q;
	logic [ICW-1:0]    inode_free_q;
	logic              done_q;
	dba_pkg::rsp_t     rsp_q;

	logic                 rd_en;
	logic [PW-1:0]        rd_word;
	logic [PW-1:0]        req_word;
	logic [WORD_BITS-1:0] d_rd_data;
	logic [WORD_BITS-1:0] i_rd_data;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] wr_word;
	logic                 d_wr_en;
	logic                 i_wr_en;
	logic                 cfg_we;
	logic                 d_clr;
	logic                 i_clr;
	logic [DCW-1:0]       d_cfg_val;
	logic [ICW-1:0]       i_cfg_val;

	logic [FW-1:0]        size_sel;
	logic [FW-1:0]        free_sel;
	logic [FW-1:0]        size_m1;
	logic [WSH-1:0]       bit_pos;
	logic                 cur_bit;
	logic                 in_range;

	dba_pkg::status_t     ev_status;
	logic                 ev_used;
	logic                 ev_wr;
	logic [FW-1:0]        free_next;

	logic [PW-1:0]        last_word;
	logic [WSH-1:0]       lim;
	logic                 at_last;
	logic [WORD_BITS-1:0] zero_vec;
	logic                 hit;
	logic [WSH-1:0]       hit_pos;
	logic [FULL_W-1:0]    found_full;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Config decode with saturation to map capacity, inode data cut to ICW bits first
	assign d_clr = cfg_we && (cfg_index == dba_pkg::REG_DATA_COUNT);
	assign i_clr = cfg_we && (cfg_index == dba_pkg::REG_INODE_COUNT);
	assign d_cfg_val = (int'(cfg_data) > DATA_BITS) ? DCW'(DATA_BITS) : cfg_data;
	assign i_cfg_val = (int'(cfg_data[ICW-1:0]) > INODE_BITS) ?
		ICW'(INODE_BITS) : cfg_data[ICW-1:0];

	// Selected map view
	assign size_sel = req_q.map_sel ? FW'(inode_count_q) : FW'(data_count_q);
	assign free_sel = req_q.map_sel ? FW'(inode_free_q) : FW'(data_free_q);
	assign word     = req_q.map_sel ? i_rd_data : d_rd_data;
	assign size_m1  = size_sel - FW'(1);
	assign req_word = PW'(req_q.bit_index >> WSH);
	assign bit_pos  = req_q.bit_index[WSH-1:0];
	assign cur_bit  = word[bit_pos];
	assign in_range = FW'(req_q.bit_index) < size_sel;

	// RAM read address: target word, or the next word of a scan
	always_comb begin
		rd_en   = (state_q == S_READ) || (state_q == S_SCAN);
		rd_word = wptr_q + PW'(1);
		if (state_q == S_READ) begin
			rd_word = (req_q.func == dba_pkg::FN_FIND) ? '0 : req_word;
		end
	end

	// Test / set / clear evaluation on the read word
	always_comb begin
		ev_status = dba_pkg::STS_OK;
		ev_used   = 1'b0;
		ev_wr     = 1'b0;
		free_next = free_sel;
		wr_word   = word;
		wr_word[bit_pos] = (req_q.func == dba_pkg::FN_SET);
		case (req_q.func)
			dba_pkg::FN_TEST: begin
				if (free_sel == '0) begin
					ev_used = 1'b1;
				end else if (!in_range) begin
					ev_status = dba_pkg::STS_RANGE;
				end else begin
					ev_used = cur_bit;
				end
			end
			dba_pkg::FN_SET: begin
				if (!in_range) begin
					ev_status = dba_pkg::STS_RANGE;
				end else if ((free_sel == '0) || cur_bit) begin
					ev_status = dba_pkg::STS_USED;
				end else begin
					ev_wr     = 1'b1;
					free_next = free_sel - FW'(1);
				end
			end
			dba_pkg::FN_CLEAR: begin
				if (!in_range) begin
					ev_status = dba_pkg::STS_RANGE;
				end else if (!cur_bit) begin
					ev_status = dba_pkg::STS_FREE;
				end else begin
					ev_wr = 1'b1;
					if (free_sel < size_sel) begin
						free_next = free_sel + FW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Scan: mask bits beyond the size in the last word, pick lowest zero
	assign last_word = PW'(size_m1 >> WSH);
	assign lim       = size_m1[WSH-1:0];
	assign at_last   = (wptr_q == last_word);

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			zero_vec[j] = !word[j] && (!at_last || (WSH'(j) <= lim));
		end
		hit     = |zero_vec;
		hit_pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (zero_vec[j]) begin
				hit_pos = WSH'(j);
			end
		end
	end

	assign found_full = (FULL_W'(wptr_q) << WSH) | FULL_W'(hit_pos);

	// Write-back of a modified word
	assign d_wr_en = (state_q == S_EVAL) && ev_wr && !req_q.map_sel;
	assign i_wr_en = (state_q == S_EVAL) && ev_wr && req_q.map_sel;

	dba_bitmap #(
		.WORDS     (DWORDS),
		.WORD_BITS (WORD_BITS)
	) u_data_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (d_clr),
		.rd_en   (rd_en),
		.rd_addr (DAW'(rd_word)),
		.rd_data (d_rd_data),
		.wr_en   (d_wr_en),
		.wr_addr (DAW'(req_word)),
		.wr_data (wr_word)
	);

	dba_bitmap #(
		.WORDS     (IWORDS),
		.WORD_BITS (WORD_BITS)
	) u_inode_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (i_clr),
		.rd_en   (rd_en),
		.rd_addr (IAW'(rd_word)),
		.rd_data (i_rd_data),
		.wr_en   (i_wr_en),
		.wr_addr (IAW'(req_word)),
		.wr_data (wr_word)
	);

	// Control: sequencer, sizes, free counters, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			data_count_q  <= DCW'(DATA_BITS);
			inode_count_q <= ICW'(INODE_BITS);
			data_free_q   <= DCW'(DATA_BITS);
			inode_free_q  <= ICW'(INODE_BITS);
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= (req_q.func == dba_pkg::FN_FIND) ? S_SCAN : S_EVAL;
				end
				S_EVAL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (ev_wr) begin
						if (req_q.map_sel) begin
							inode_free_q <= ICW'(free_next);
						end else begin
							data_free_q <= DCW'(free_next);
						end
					end
				end
				S_SCAN: begin
					if ((free_sel == '0) || hit || at_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (d_clr) begin
				data_count_q <= d_cfg_val;
				data_free_q  <= d_cfg_val;
			end
			if (i_clr) begin
				inode_count_q <= i_cfg_val;
				inode_free_q  <= i_cfg_val;
			end
		end
	end

	// Payload registers: request, scan pointer, result
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			req_q <= req;
		end
		if (state_q == S_READ) begin
			wptr_q <= '0;
		end else if (state_q == S_SCAN) begin
			wptr_q <= wptr_q + PW'(1);
		end
		if (state_q == S_EVAL) begin
			rsp_q.status      <= ev_status;
			rsp_q.used        <= ev_used;
			rsp_q.found_index <= '0;
			rsp_q.free_left   <= free_next;
		end else if (state_q == S_SCAN) begin
			rsp_q.used      <= 1'b0;
			rsp_q.free_left <= free_sel;
			if ((free_sel != '0) && hit) begin
				rsp_q.status      <= dba_pkg::STS_OK;
				rsp_q.found_index <= dba_pkg::IDX_W'(found_full);
			end else begin
				rsp_q.status      <= dba_pkg::STS_NONE;
				rsp_q.found_index <= '0;
			end
		end
	end

endmodule

@@ src/dba_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the allocator's request/result sequencing
module dba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input dba_pkg::rsp_t rsp
);

	// An accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// Work ends exactly when its result is strobed
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// One result per transaction, never back to back
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("result strobe repeated or overlaps work");

	// A used report only comes with an ok status
	a_used_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.used |-> rsp.status == dba_pkg::STS_OK)
		else $error("used set with error status");

	// Nothing found means index zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == dba_pkg::STS_NONE) |-> rsp.found_index == '0)
		else $error("found_index nonzero with none free");

endmodule

bind dual_bitmap_allocator dba_checker u_dba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

@@ dv/dual_bitmap_allocator_test.sv @@
`timescale 1ns / 1ps

module dual_bitmap_allocator_test;

	localparam int unsigned RUN_LIMIT   = 1_000_000;
	localparam int          PHASES      = 10;
	localparam int          PHASE_ITEMS = 93;
	localparam int          TAIL_CYCLES = 140;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	logic                           busy;
	dba_pkg::req_t                  req       = '0;
	logic                           done;
	dba_pkg::rsp_t                  rsp;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [dba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dba_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	dual_bitmap_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One step of the directed plan: a request or a register write
	typedef struct {
		bit                             is_cfg;
		bit                             typed;
		dba_pkg::req_t                  rq;
		logic [dba_pkg::CFG_IDX_W-1:0]  ci;
		logic [dba_pkg::CFG_DATA_W-1:0] cd;
		dba_pkg::rsp_t                  want;
	} row_t;

	// Shadow copy of both maps, their sizes and free counters
	bit          data_bm  [dba_pkg::DATA_BITS_DEF];
	bit          inode_bm [dba_pkg::INODE_BITS_DEF];
	int unsigned data_len    = dba_pkg::DATA_BITS_DEF;
	int unsigned inode_len   = dba_pkg::INODE_BITS_DEF;
	int unsigned data_avail  = dba_pkg::DATA_BITS_DEF;
	int unsigned inode_avail = dba_pkg::INODE_BITS_DEF;

	dba_pkg::rsp_t outcome_q [$];
	int unsigned   mismatches = 0;
	int unsigned   cycles     = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result of one request on the shadow maps; find leaves them untouched
	function automatic dba_pkg::rsp_t bitmap_outcome(dba_pkg::req_t rq);
		dba_pkg::rsp_t o;
		int unsigned   len, avail, idx, b;
		bit            cur;
		len   = rq.map_sel ? inode_len : data_len;
		avail = rq.map_sel ? inode_avail : data_avail;
		idx   = rq.bit_index;
		cur   = 1'b0;
		if (idx < len)
			cur = rq.map_sel ? inode_bm[idx] : data_bm[idx];
		o.status      = dba_pkg::STS_OK;
		o.used        = 1'b0;
		o.found_index = '0;
		case (rq.func)
		dba_pkg::FN_TEST: begin
			// a full map reads as used before the range check
			if (avail == 0)
				o.used = 1'b1;
			else if (idx >= len)
				o.status = dba_pkg::STS_RANGE;
			else
				o.used = cur;
		end
		dba_pkg::FN_SET: begin
			if (idx >= len)
				o.status = dba_pkg::STS_RANGE;
			else if (avail == 0 || cur)
				o.status = dba_pkg::STS_USED;
			else begin
				if (rq.map_sel)
					inode_bm[idx] = 1'b1;
				else
					data_bm[idx] = 1'b1;
				avail--;
			end
		end
		dba_pkg::FN_CLEAR: begin
			if (idx >= len)
				o.status = dba_pkg::STS_RANGE;
			else if (!cur)
				o.status = dba_pkg::STS_FREE;
			else begin
				if (rq.map_sel)
					inode_bm[idx] = 1'b0;
				else
					data_bm[idx] = 1'b0;
				if (avail < len)
					avail++;
			end
		end
		dba_pkg::FN_FIND: begin
			o.status = dba_pkg::STS_NONE;
			if (avail != 0) begin
				for (b = 0; b < len; b++) begin
					if (!(rq.map_sel ? inode_bm[b] : data_bm[b])) begin
						o.status      = dba_pkg::STS_OK;
						o.found_index = dba_pkg::IDX_W'(b);
						break;
					end
				end
			end
		end
		endcase
		if (rq.map_sel)
			inode_avail = avail;
		else
			data_avail = avail;
		o.free_left = dba_pkg::FREE_W'(avail);
		return o;
	endfunction

	// Size write: saturate, empty the map, refill the counter
	function automatic void resize_map(logic [dba_pkg::CFG_IDX_W-1:0] ci,
			logic [dba_pkg::CFG_DATA_W-1:0] cd);
		int unsigned v;
		if (ci == dba_pkg::REG_DATA_COUNT) begin
			v = cd;
			if (v > dba_pkg::DATA_BITS_DEF)
				v = dba_pkg::DATA_BITS_DEF;
			data_len   = v;
			data_avail = v;
			data_bm    = '{default: 1'b0};
		end else if (ci == dba_pkg::REG_INODE_COUNT) begin
			v = cd[dba_pkg::INODE_CW-1:0];
			if (v > dba_pkg::INODE_BITS_DEF)
				v = dba_pkg::INODE_BITS_DEF;
			inode_len   = v;
			inode_avail = v;
			inode_bm    = '{default: 1'b0};
		end
	endfunction

	function automatic row_t op_row(dba_pkg::func_t f, bit sel, int unsigned idx);
		row_t r;
		r.is_cfg           = 1'b0;
		r.typed            = 1'b0;
		r.rq.func          = f;
		r.rq.map_sel       = sel;
		r.rq.bit_index     = dba_pkg::IDX_W'(idx);
		r.ci               = '0;
		r.cd               = '0;
		r.want.status      = dba_pkg::STS_OK;
		r.want.used        = 1'b0;
		r.want.found_index = '0;
		r.want.free_left   = '0;
		return r;
	endfunction

	function automatic row_t chk_row(dba_pkg::func_t f, bit sel, int unsigned idx,
			dba_pkg::status_t st, bit u, int unsigned found, int unsigned avail);
		row_t r;
		r                  = op_row(f, sel, idx);
		r.typed            = 1'b1;
		r.want.status      = st;
		r.want.used        = u;
		r.want.found_index = dba_pkg::IDX_W'(found);
		r.want.free_left   = dba_pkg::FREE_W'(avail);
		return r;
	endfunction

	function automatic row_t cfg_row(logic [dba_pkg::CFG_IDX_W-1:0] ci, int unsigned cd);
		row_t r;
		r        = op_row(dba_pkg::FN_TEST, 1'b0, 0);
		r.is_cfg = 1'b1;
		r.ci     = ci;
		r.cd     = dba_pkg::CFG_DATA_W'(cd);
		return r;
	endfunction

	// Mostly small sizes, some medium, now and then an extreme or an oversize value
	function automatic logic [dba_pkg::CFG_DATA_W-1:0] pick_size(int unsigned cap);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			case ($urandom_range(0, 2))
			0: return '0;
			1: return dba_pkg::CFG_DATA_W'(cap);
			default: return dba_pkg::CFG_DATA_W'($urandom_range(cap + 1, 8191));
			endcase
		end
		if (roll < 3)
			return dba_pkg::CFG_DATA_W'($urandom_range(49, cap * 3 / 16));
		return dba_pkg::CFG_DATA_W'($urandom_range(1, 48));
	endfunction

	// Present a request, wait for the transaction, then record its outcome
	task automatic send(row_t r);
		dba_pkg::rsp_t got;
		start <= 1'b1;
		req   <= r.rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = bitmap_outcome(r.rq);
		outcome_q.push_back(r.typed ? r.want : got);
	endtask

	// Stop issuing and let every outstanding result come back
	task automatic settle();
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [dba_pkg::CFG_IDX_W-1:0] ci,
			logic [dba_pkg::CFG_DATA_W-1:0] cd);
		cfg_valid <= 1'b1;
		cfg_index <= ci;
		cfg_data  <= cd;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		resize_map(ci, cd);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stimulus: directed plan, then random phases with fresh map sizes
	initial begin : stimulus
		row_t          plan [$];
		row_t          r;
		dba_pkg::rsp_t peek;
		int unsigned   len, spot, pick, burst, gap;
		bit            sel;

		// defaults after reset: 4096 data bits, 1024 inode bits
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b0, 0,    dba_pkg::STS_OK,    1'b0, 0, 4096));
		plan.push_back(chk_row(dba_pkg::FN_FIND,  1'b0, 4095, dba_pkg::STS_OK,    1'b0, 0, 4096));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b0, 0,    dba_pkg::STS_OK,    1'b0, 0, 4095));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b0, 0,    dba_pkg::STS_USED,  1'b0, 0, 4095));
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b0, 0,    dba_pkg::STS_OK,    1'b1, 0, 4095));
		plan.push_back(chk_row(dba_pkg::FN_FIND,  1'b0, 0,    dba_pkg::STS_OK,    1'b0, 1, 4095));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b0, 4095, dba_pkg::STS_OK,    1'b0, 0, 4094));
		plan.push_back(chk_row(dba_pkg::FN_CLEAR, 1'b0, 4095, dba_pkg::STS_OK,    1'b0, 0, 4095));
		plan.push_back(chk_row(dba_pkg::FN_CLEAR, 1'b0, 4095, dba_pkg::STS_FREE,  1'b0, 0, 4095));
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b1, 1024, dba_pkg::STS_RANGE, 1'b0, 0, 1024));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b1, 1023, dba_pkg::STS_OK,    1'b0, 0, 1023));
		plan.push_back(chk_row(dba_pkg::FN_CLEAR, 1'b1, 4095, dba_pkg::STS_RANGE, 1'b0, 0, 1023));
		plan.push_back(op_row(dba_pkg::FN_FIND, 1'b1, 0));
		// empty data map: always full, every index out of range
		plan.push_back(cfg_row(dba_pkg::REG_DATA_COUNT, 0));
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b0, 0,    dba_pkg::STS_OK,    1'b1, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b0, 0,    dba_pkg::STS_RANGE, 1'b0, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_CLEAR, 1'b0, 0,    dba_pkg::STS_RANGE, 1'b0, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_FIND,  1'b0, 0,    dba_pkg::STS_NONE,  1'b0, 0, 0));
		// one-bit inode map, filled then freed
		plan.push_back(cfg_row(dba_pkg::REG_INODE_COUNT, 1));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b1, 0,    dba_pkg::STS_OK,    1'b0, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b1, 5,    dba_pkg::STS_OK,    1'b1, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_FIND,  1'b1, 0,    dba_pkg::STS_NONE,  1'b0, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_SET,   1'b1, 0,    dba_pkg::STS_USED,  1'b0, 0, 0));
		plan.push_back(chk_row(dba_pkg::FN_CLEAR, 1'b1, 0,    dba_pkg::STS_OK,    1'b0, 0, 1));
		// unknown register indexes are dropped
		plan.push_back(cfg_row(2'd2, 8191));
		plan.push_back(cfg_row(2'd3, 0));
		plan.push_back(op_row(dba_pkg::FN_TEST, 1'b1, 0));
		// oversize writes saturate to capacity
		plan.push_back(cfg_row(dba_pkg::REG_DATA_COUNT, 8191));
		plan.push_back(cfg_row(dba_pkg::REG_INODE_COUNT, 2047));
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b0, 4095, dba_pkg::STS_OK,    1'b0, 0, 4096));
		plan.push_back(chk_row(dba_pkg::FN_TEST,  1'b1, 1023, dba_pkg::STS_OK,    1'b0, 0, 1024));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				cfg_write(plan[i].ci, plan[i].cd);
			end else
				send(plan[i]);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			cfg_write(dba_pkg::REG_DATA_COUNT, pick_size(dba_pkg::DATA_BITS_DEF));
			cfg_write(dba_pkg::REG_INODE_COUNT, pick_size(dba_pkg::INODE_BITS_DEF));
			burst = $urandom_range(1, 20);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel  = $urandom_range(0, 1);
				len  = sel ? inode_len : data_len;
				spot = (len != 0) ? $urandom_range(0, len - 1) : $urandom_range(0, 4095);
				// lowest free bit right now, so allocations fill the map from the bottom
				r    = op_row(dba_pkg::FN_FIND, sel, 0);
				peek = bitmap_outcome(r.rq);
				pick = $urandom_range(0, 99);
				if (pick < 10)
					r = op_row(dba_pkg::func_t'($urandom_range(0, 3)), sel,
						$urandom_range(0, 4095));
				else if (pick < 35)
					r = op_row(dba_pkg::FN_FIND, sel, $urandom_range(0, 4095));
				else if (pick < 55)
					r = op_row(dba_pkg::FN_SET, sel,
						(peek.status == dba_pkg::STS_OK) ? peek.found_index : spot);
				else if (pick < 65)
					r = op_row(dba_pkg::FN_SET, sel, spot);
				else if (pick < 85) begin
					// below the lowest free bit everything is in use
					if (peek.status == dba_pkg::STS_OK && peek.found_index != 0)
						spot = $urandom_range(0, peek.found_index - 1);
					r = op_row(dba_pkg::FN_CLEAR, sel, spot);
				end else
					r = op_row(dba_pkg::FN_TEST, sel, $urandom_range(0, len));
				send(r);

				// bursts of back-to-back requests, mostly separated by idle gaps
				burst--;
				if (burst == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					if (gap != 0) begin
						start <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 12);
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Each done strobe is one result transaction, checked against the oldest outcome
	always @(posedge clk) begin : result_check
		dba_pkg::rsp_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: result with nothing outstanding: ",
						"status %0d used %0d found %0d free %0d"},
						$time, rsp.status, rsp.used, rsp.found_index, rsp.free_left);
			end else begin
				want = outcome_q.pop_front();
				if (rsp.status !== want.status || rsp.used !== want.used
						|| rsp.found_index !== want.found_index
						|| rsp.free_left !== want.free_left) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: exp st %0d u %0d fnd %0d free %0d, ",
							"got st %0d u %0d fnd %0d free %0d"},
							$time, want.status, want.used, want.found_index, want.free_left,
							rsp.status, rsp.used, rsp.found_index, rsp.free_left);
				end
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ dual_bitmap_allocator.f @@
src/dba_pkg.sv
src/dba_bitmap.sv
src/dual_bitmap_allocator.sv
src/dba_checker.sv
dv/dual_bitmap_allocator_test.sv
